@@ sv/pidg_pkg.sv @@
// Shared types and constants for the PID drive generator with rate guard.
package pidg_pkg;
   localparam int ERR_DEPTH_DEF   = 16;
   localparam int DRIVE_DEPTH_DEF = 8;
   localparam int ErrW   = 17;
   localparam int SumW   = 25;
   localparam int NumW   = 26;
   localparam int DivW   = 16;
   localparam int DriveW = 8;

   typedef enum logic [2:0] {
      CFG_PROP  = 3'd0,
      CFG_INTEG = 3'd1,
      CFG_DERIV = 3'd2,
      CFG_SETPT = 3'd3,
      CFG_GUARD = 3'd4,
      CFG_MAXPW = 3'd5
   } cfg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_NEXT,
      ST_GUARD,
      ST_OUT
   } state_type;
endpackage

@@ sv/pid_pwm_with_rate_guard.sv @@
// Top level of the PID drive generator with windowed integral and rate guard.
// Each item runs its three terms (proportional, integral, derivative) in turn on the
// shared 26-bit bit-serial divider, starting it and waiting for its result each time.
// An item is taken only while no other is in flight; the next item is taken the cycle
// after the result has left. Reset is synchronous and active high; it restores register
// defaults and clears the error and drive histories through their valid bits.
module pid_pwm_with_rate_guard #(
   parameter int ERR_DEPTH   = pidg_pkg::ERR_DEPTH_DEF,
   parameter int DRIVE_DEPTH = pidg_pkg::DRIVE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] drive
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int EPW = (ERR_DEPTH > 1) ? $clog2(ERR_DEPTH) : 1;
   localparam int DPW = (DRIVE_DEPTH > 1) ? $clog2(DRIVE_DEPTH) : 1;
   localparam int NumW = pidg_pkg::NumW;

   // Configuration registers.
   logic [15:0] prop_ff, integ_ff, deriv_ff;
   logic signed [15:0] setpt_ff;
   logic guard_ff;
   logic [7:0] maxpw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_ff <= 16'd1; integ_ff <= 16'd1; deriv_ff <= 16'd1;
         setpt_ff <= '0; guard_ff <= 1'b1; maxpw_ff <= 8'd255;
      end else if (csr_we) begin
         case (csr_index)
            pidg_pkg::CFG_PROP:  prop_ff  <= csr_wdata;
            pidg_pkg::CFG_INTEG: integ_ff <= csr_wdata;
            pidg_pkg::CFG_DERIV: deriv_ff <= csr_wdata;
            pidg_pkg::CFG_SETPT: setpt_ff <= csr_wdata;
            pidg_pkg::CFG_GUARD: guard_ff <= csr_wdata[0];
            pidg_pkg::CFG_MAXPW: maxpw_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // History stores; an entry without its valid bit reads as zero.
   logic signed [pidg_pkg::ErrW-1:0] err_mem [ERR_DEPTH];
   logic [ERR_DEPTH-1:0] err_vld_ff;
   logic [pidg_pkg::DriveW-1:0] drv_mem [DRIVE_DEPTH];
   logic [DRIVE_DEPTH-1:0] drv_vld_ff;
   logic [EPW-1:0] eptr_ff;
   logic [DPW-1:0] dptr_ff;
   logic signed [pidg_pkg::SumW-1:0] sum_ff;

   pidg_pkg::state_type state_ff, state_in;
   logic [1:0] term_ff;
   logic signed [pidg_pkg::ErrW-1:0] err_ff, prev_ff, oldslot_ff;
   logic signed [NumW-1:0] total_ff;
   logic [7:0] oldest_ff, drive_ff;
   logic [EPW-1:0] eslot;
   logic [DPW-1:0] dslot, dold;

   assign eslot = (eptr_ff == EPW'(ERR_DEPTH-1)) ? '0 : eptr_ff + EPW'(1);
   assign dslot = (dptr_ff == DPW'(DRIVE_DEPTH-1)) ? '0 : dptr_ff + DPW'(1);
   assign dold  = (dslot == DPW'(DRIVE_DEPTH-1)) ? '0 : dslot + DPW'(1);

   // Shared divider.
   logic div_start, div_done;
   logic signed [NumW-1:0] div_num, div_q;
   logic [15:0] div_den;

   always_comb begin
      case (term_ff)
         2'd0: begin
            div_num = NumW'(err_ff) * NumW'(10); div_den = prop_ff;
         end
         2'd1: begin div_num = NumW'(sum_ff); div_den = integ_ff; end
         default: begin
            div_num = (NumW'(prev_ff) - NumW'(err_ff)) * NumW'(10);
            div_den = deriv_ff;
         end
      endcase
   end

   pidg_sdiv u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(div_num), .den(div_den), .done(div_done), .quot(div_q)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pidg_pkg::ST_IDLE:  if (req_tvalid) state_in = pidg_pkg::ST_READ;
         pidg_pkg::ST_READ:  state_in = pidg_pkg::ST_DIV;
         pidg_pkg::ST_DIV:   state_in = pidg_pkg::ST_NEXT;
         pidg_pkg::ST_NEXT:
            if (div_done)
               state_in = (term_ff == 2'd2) ? pidg_pkg::ST_GUARD : pidg_pkg::ST_DIV;
         pidg_pkg::ST_GUARD: state_in = pidg_pkg::ST_OUT;
         pidg_pkg::ST_OUT:   if (rsp_tready) state_in = pidg_pkg::ST_IDLE;
         default:            state_in = pidg_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_tready = (state_ff == pidg_pkg::ST_IDLE);
      rsp_tvalid = (state_ff == pidg_pkg::ST_OUT);
      div_start  = (state_ff == pidg_pkg::ST_DIV);
   end
   assign rsp_tdata = drive_ff;

   // Clamp of the finished sum, then guard against the oldest drive or halve on a large negative error.
   logic [7:0] clamped, guarded;
   logic signed [9:0] gdiff;
   always_comb begin
      if (total_ff > $signed(NumW'(maxpw_ff))) clamped = maxpw_ff;
      else if (total_ff < 0)                  clamped = '0;
      else                                    clamped = total_ff[7:0];
      gdiff = $signed({2'b0, clamped}) - $signed({2'b0, oldest_ff});
      guarded = clamped;
      if (guard_ff) begin
         if (gdiff >= 10'sd5)       guarded = oldest_ff + 8'd5;
         else if (gdiff <= -10'sd5) guarded = oldest_ff - 8'd5;
         else if (err_ff <= -17'sd20) guarded = clamped >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pidg_pkg::ST_IDLE;
         err_vld_ff <= '0; drv_vld_ff <= '0;
         eptr_ff <= '0; dptr_ff <= '0; sum_ff <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            pidg_pkg::ST_IDLE: if (req_tvalid) begin
               err_ff <= pidg_pkg::ErrW'(setpt_ff) - pidg_pkg::ErrW'($signed(req_tdata));
               term_ff <= 2'd0;
               total_ff <= '0;
            end
            pidg_pkg::ST_READ: begin
               prev_ff    <= err_vld_ff[eptr_ff] ? err_mem[eptr_ff] : '0;
               oldslot_ff <= err_vld_ff[eslot] ? err_mem[eslot] : '0;
               oldest_ff  <= drv_vld_ff[dold] ? drv_mem[dold] : '0;
            end
            pidg_pkg::ST_NEXT: if (div_done) begin
               total_ff <= total_ff + div_q;
               term_ff  <= term_ff + 2'd1;
            end
            pidg_pkg::ST_GUARD: begin
               sum_ff <= sum_ff + pidg_pkg::SumW'(err_ff) - pidg_pkg::SumW'(oldslot_ff);
               err_mem[eslot] <= err_ff;
               err_vld_ff[eslot] <= 1'b1;
               eptr_ff <= eslot;
               drv_mem[dslot] <= guarded;
               drv_vld_ff[dslot] <= 1'b1;
               dptr_ff <= dslot;
               drive_ff <= guarded;
            end
            default: ;
         endcase
      end
   end
endmodule

@@ sv/pidg_sdiv.sv @@
// Bit-serial signed divider: one quotient bit per cycle, truncating toward zero.
module pidg_sdiv (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [pidg_pkg::NumW-1:0]      num,
   input  logic [pidg_pkg::DivW-1:0]             den,
   output logic                                  done,
   output logic signed [pidg_pkg::NumW-1:0]      quot
);
   localparam int CntW = $clog2(pidg_pkg::NumW + 1);

   logic [pidg_pkg::NumW-1:0] q_ff, q_in;
   logic [pidg_pkg::DivW:0]   r_ff, r_in;
   logic [pidg_pkg::DivW-1:0] d_ff, d_in;
   logic                      neg_ff, neg_in;
   logic [CntW-1:0]           cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic [pidg_pkg::DivW:0]   trial;
   logic [pidg_pkg::DivW:0]   diff;

   always_comb begin
      trial = {r_ff[pidg_pkg::DivW-1:0], q_ff[pidg_pkg::NumW-1]};
      diff  = trial - {1'b0, d_ff};
   end

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      if (start) begin
         q_in    = num[pidg_pkg::NumW-1] ? -num : num;
         r_in    = '0;
         d_in    = (den == '0) ? pidg_pkg::DivW'(1) : den;
         neg_in  = num[pidg_pkg::NumW-1];
         cnt_in  = CntW'(pidg_pkg::NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[pidg_pkg::DivW]) begin
            r_in = diff;
            q_in = {q_ff[pidg_pkg::NumW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[pidg_pkg::NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; neg_ff <= neg_in; cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   assign done = !busy_ff;
   assign quot = neg_ff ? -q_ff : q_ff;
endmodule
